@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Every assertion samples on the rising clock edge and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on the current cycle.
`define QTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition that must bring another one in the next cycle.
`define QTE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ design/qte_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared package
// Widths, constants, the payload types and the arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int ITER = (ANGLE_ITERATIONS < 30) ? ANGLE_ITERATIONS : 30;

	localparam int QW  = 32;        // input component width
	localparam int PW  = 34;        // Q30 product width
	localparam int VW  = 36;        // vector component width after sums
	localparam int SW  = 32;        // clamped sine width
	localparam int CW  = 40;        // rotator datapath width
	localparam int AW  = 35;        // angle accumulator width
	localparam int RW  = 62;        // square root remainder and root width
	localparam int MW  = 49;        // scaled angle product width
	localparam int UW  = MW - 30;   // scaled angle width before saturation
	localparam int SQ_STEPS = 31;   // one root bit per stage

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int ODEPTH = 2;

	localparam logic signed [SW-1:0] Q30_ONE   = 32'sd1073741824;
	localparam logic signed [AW-1:0] PI_Q30    = 35'sd3373259426;
	localparam logic signed [13:0]   DEG_SCALE = 14'sd5730;
	localparam logic signed [UW-1:0] ROLL_LIMIT  = 19'sd18001;
	localparam logic signed [UW-1:0] PITCH_LIMIT = 19'sd9001;

	typedef struct packed {
		logic signed [SW-1:0] s;
		logic                 clamped;
		logic signed [VW-1:0] ry;
		logic signed [VW-1:0] rx;
		logic signed [VW-1:0] yy;
		logic signed [VW-1:0] yx;
	} qte_item_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
	} qte_result_t;

	// Product of two Q30 values, floored back to Q30.
	function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [2*QW-1:0] p;
		p = a * b;
		return p[2*QW-1:30];
	endfunction

	function automatic logic signed [UW-1:0] sat(input logic signed [UW-1:0] v,
			input logic signed [UW-1:0] lim);
		logic signed [UW-1:0] r;
		r = v;
		if (v > lim)
			r = lim;
		if (v < -lim)
			r = -lim;
		return r;
	endfunction

	// atan(2^-i) in Q30 radians.
	function automatic logic signed [AW-1:0] atan_q30(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 35'sd843314857;
			1: r = 35'sd497837829;
			2: r = 35'sd263043837;
			3: r = 35'sd133525159;
			4: r = 35'sd67021687;
			5: r = 35'sd33543516;
			6: r = 35'sd16775851;
			7: r = 35'sd8388437;
			8: r = 35'sd4194283;
			9: r = 35'sd2097149;
			10: r = 35'sd1048576;
			11: r = 35'sd524288;
			12: r = 35'sd262144;
			13: r = 35'sd131072;
			14: r = 35'sd65536;
			15: r = 35'sd32768;
			16: r = 35'sd16384;
			17: r = 35'sd8192;
			18: r = 35'sd4096;
			19: r = 35'sd2048;
			20: r = 35'sd1024;
			21: r = 35'sd512;
			22: r = 35'sd256;
			23: r = 35'sd128;
			24: r = 35'sd64;
			25: r = 35'sd32;
			26: r = 35'sd16;
			27: r = 35'sd8;
			28: r = 35'sd4;
			29: r = 35'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/quaternion_to_euler_angles_top.sv @@
`default_nettype none
// One attitude quaternion (Q30) is taken per clock while full is low, and roll,
// pitch and yaw come out in hundredths of a degree, in input order, after
// passing two front stages, the four-entry queue, 32
// square root stages, ANGLE_ITERATIONS + 1 rotator stages and two scaling
// stages. The sustained rate is one item per cycle, set by the fully
// pipelined square root and rotators; full rises only when results back up.
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: top level
// Front end with queue feeding the pipelined back end.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);

	qte_item_t head;
	logic head_vld, head_pop;

	qte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z),
		.head     (head),
		.head_vld (head_vld),
		.head_pop (head_pop)
	);

	qte_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_vld      (head_vld),
		.head_pop      (head_pop),
		.empty         (empty),
		.pop           (pop),
		.roll_angle    (roll_angle),
		.pitch_angle   (pitch_angle),
		.yaw_angle     (yaw_angle),
		.pitch_clamped (pitch_clamped)
	);

endmodule
`default_nettype wire

@@ design/qte_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: front end
// Registers the quaternion, forms the Q30 products and sums, clamps the sine
// of pitch and queues the prepared vectors for the back end.
// ----------------------------------------------------------------------------
module qte_front import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [QW-1:0] quat_w,
	input  logic signed [QW-1:0] quat_x,
	input  logic signed [QW-1:0] quat_y,
	input  logic signed [QW-1:0] quat_z,
	output qte_item_t            head,
	output logic                 head_vld,
	input  logic                 head_pop
);

	logic en;
	logic accept;
	logic vld_s1, vld_s2;
	logic signed [QW-1:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [PW-1:0] wy_s2, xz_s2, yz_s2, wx_s2, xx_s2;
	logic signed [PW-1:0] yy_s2, xy_s2, wz_s2, ww_s2, zz_s2;
	logic signed [VW-1:0] s_raw;
	qte_item_t item;

	qte_item_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0] cnt_q;
	logic q_push, q_pop;

	assign en     = cnt_q < (QAW+1)'(QDEPTH);
	assign full   = !en;
	assign accept = push && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= quat_w;
			x_s1  <= quat_x;
			y_s1  <= quat_y;
			z_s1  <= quat_z;
			wy_s2 <= mulq(w_s1, y_s1);
			xz_s2 <= mulq(x_s1, z_s1);
			yz_s2 <= mulq(y_s1, z_s1);
			wx_s2 <= mulq(w_s1, x_s1);
			xx_s2 <= mulq(x_s1, x_s1);
			yy_s2 <= mulq(y_s1, y_s1);
			xy_s2 <= mulq(x_s1, y_s1);
			wz_s2 <= mulq(w_s1, z_s1);
			ww_s2 <= mulq(w_s1, w_s1);
			zz_s2 <= mulq(z_s1, z_s1);
		end
	end

	always_comb begin
		s_raw = (VW'(wy_s2) - VW'(xz_s2)) <<< 1;
		item.ry = (VW'(yz_s2) + VW'(wx_s2)) <<< 1;
		item.rx = VW'(Q30_ONE) - (VW'(xx_s2) <<< 1) - (VW'(yy_s2) <<< 1);
		item.yy = (VW'(xy_s2) + VW'(wz_s2)) <<< 1;
		item.yx = VW'(ww_s2) + VW'(xx_s2) - VW'(yy_s2) - VW'(zz_s2);
		priority if (s_raw > VW'(Q30_ONE)) begin
			item.s       = Q30_ONE;
			item.clamped = 1'b1;
		end else if (s_raw < -VW'(Q30_ONE)) begin
			item.s       = -Q30_ONE;
			item.clamped = 1'b1;
		end else begin
			item.s       = s_raw[SW-1:0];
			item.clamped = 1'b0;
		end
	end

	// Queue between the front and back ends.
	assign q_push   = vld_s2 && en;
	assign head_vld = cnt_q != '0;
	assign q_pop    = head_pop && head_vld;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push)
				wr_q <= wr_q + 1'b1;
			if (q_pop)
				rd_q <= rd_q + 1'b1;
			if (q_push && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!q_push && q_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_push)
			mem_q[wr_q] <= item;
	end

endmodule
`default_nettype wire

@@ design/qte_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: cosine of pitch
// Pipelined integer square root of 2^60 - s^2, one root bit per stage; the
// rest of the item travels alongside.
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  qte_item_t   in_item,
	output logic        out_vld,
	output qte_item_t   out_item,
	output logic [30:0] root
);

	logic                 vld_s  [SQ_STEPS+1];
	logic [RW-1:0]        rem_s  [SQ_STEPS+1];
	logic [RW-1:0]        root_s [SQ_STEPS+1];
	qte_item_t            item_s [SQ_STEPS+1];
	logic signed [2*SW-1:0] sq;

	assign sq = in_item.s * in_item.s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= (RW'(1) << 60) - RW'(sq);
			root_s[0] <= '0;
			item_s[0] <= in_item;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [RW-1:0] bitv;
		logic [RW-1:0] trial;
		logic          ge;

		assign bitv  = RW'(1) << (60 - 2*k);
		assign trial = root_s[k] + bitv;
		assign ge    = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[k+1] <= item_s[k];
				if (ge) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + bitv;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign out_vld  = vld_s[SQ_STEPS];
	assign out_item = item_s[SQ_STEPS];
	assign root     = root_s[SQ_STEPS][30:0];

endmodule
`default_nettype wire

@@ design/qte_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: vectoring rotator
// Pipelined atan2: a quadrant stage, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	output logic                 out_vld,
	output logic signed [AW-1:0] angle
);

	logic                 vld_s  [ITER+1];
	logic                 zero_s [ITER+1];
	logic signed [CW-1:0] x_s    [ITER+1];
	logic signed [CW-1:0] y_s    [ITER+1];
	logic signed [AW-1:0] acc_s  [ITER+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_vld;
	end

	// A vector in the left half plane is turned by pi first.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0]   <= -x_in;
				y_s[0]   <= -y_in;
				acc_s[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s[0]   <= x_in;
				y_s[0]   <= y_in;
				acc_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		logic signed [CW-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1]   <= x_s[i] + dx;
					y_s[i+1]   <= y_s[i] - dy;
					acc_s[i+1] <= acc_s[i] + atan_q30(i);
				end else begin
					x_s[i+1]   <= x_s[i] - dx;
					y_s[i+1]   <= y_s[i] + dy;
					acc_s[i+1] <= acc_s[i] - atan_q30(i);
				end
			end
		end
	end

	assign out_vld = vld_s[ITER];
	assign angle   = zero_s[ITER] ? '0 : acc_s[ITER];

endmodule
`default_nettype wire

@@ design/qte_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: back end
// Square root, three rotators, scaling to hundredths of a degree with
// saturation, and the result queue.
// ----------------------------------------------------------------------------
module qte_back import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  qte_item_t          head,
	input  logic               head_vld,
	output logic               head_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);

	localparam int CLAT = ITER + 1;

	logic en;
	logic sq_vld;
	qte_item_t sq_item;
	logic [30:0] sq_root;
	logic r_vld, p_vld, y_vld;
	logic signed [AW-1:0] r_ang, p_ang, y_ang;
	logic clamp_s [CLAT];

	logic vld_m;
	logic clamp_m;
	logic signed [MW-1:0] rprod_m, pprod_m, yprod_m;
	qte_result_t res;

	qte_result_t mem_q [ODEPTH];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        o_push, o_pop;

	// The whole back end moves together and stops while the result queue is full.
	assign en       = cnt_q < 2'(ODEPTH);
	assign head_pop = en && head_vld;

	qte_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (head_vld),
		.in_item  (head),
		.out_vld  (sq_vld),
		.out_item (sq_item),
		.root     (sq_root)
	);

	qte_cordic u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.y_in    (CW'(sq_item.ry)),
		.x_in    (CW'(sq_item.rx)),
		.out_vld (r_vld),
		.angle   (r_ang)
	);

	qte_cordic u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.y_in    (CW'(sq_item.s)),
		.x_in    ($signed({(CW-31)'(0), sq_root})),
		.out_vld (p_vld),
		.angle   (p_ang)
	);

	qte_cordic u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.y_in    (CW'(sq_item.yy)),
		.x_in    (CW'(sq_item.yx)),
		.out_vld (y_vld),
		.angle   (y_ang)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s[0] <= sq_item.clamped;
			for (int k = 1; k < CLAT; k++)
				clamp_s[k] <= clamp_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m <= 1'b0;
		else if (en)
			vld_m <= r_vld && p_vld && y_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rprod_m <= r_ang * DEG_SCALE;
			pprod_m <= p_ang * DEG_SCALE;
			yprod_m <= y_ang * DEG_SCALE;
			clamp_m <= clamp_s[CLAT-1];
		end
	end

	// Adding half an LSB before the floor shift rounds half up.
	always_comb begin
		logic signed [MW-1:0] rr, pr, yr;
		logic signed [UW-1:0] rs, ps, ys;
		rr = rprod_m + (MW'(1) <<< 29);
		pr = pprod_m + (MW'(1) <<< 29);
		yr = yprod_m + (MW'(1) <<< 29);
		rs = sat(rr[MW-1:30], ROLL_LIMIT);
		ps = sat(pr[MW-1:30], PITCH_LIMIT);
		ys = sat(yr[MW-1:30], ROLL_LIMIT);
		res.roll    = rs[15:0];
		res.pitch   = ps[14:0];
		res.yaw     = ys[15:0];
		res.clamped = clamp_m;
	end

	assign o_push = vld_m && en;
	assign empty  = cnt_q == '0;
	assign o_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (o_push)
				wr_q <= !wr_q;
			if (o_pop)
				rd_q <= !rd_q;
			if (o_push && !o_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!o_push && o_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_push)
			mem_q[wr_q] <= res;
	end

	assign roll_angle    = mem_q[rd_q].roll;
	assign pitch_angle   = mem_q[rd_q].pitch;
	assign yaw_angle     = mem_q[rd_q].yaw;
	assign pitch_clamped = mem_q[rd_q].clamped;

endmodule
`default_nettype wire

@@ design/qte_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: port checker
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qte_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [15:0] roll_angle,
	input logic signed [14:0] pitch_angle,
	input logic signed [15:0] yaw_angle,
	input logic               pitch_clamped
);

	`QTE_ASSERT(a_pitch_range, !empty |-> (pitch_angle <= 9001 && pitch_angle >= -9001), "pitch out of range")
	`QTE_ASSERT(a_roll_range, !empty |-> (roll_angle <= 18001 && roll_angle >= -18001), "roll out of range")
	`QTE_ASSERT(a_yaw_range, !empty |-> (yaw_angle <= 18001 && yaw_angle >= -18001), "yaw out of range")
	`QTE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(roll_angle) && $stable(pitch_clamped), "waiting result changed")

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);
`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: testbench
// Drives Q30 quaternions into the block through its queue interface and checks
// roll, pitch, yaw and the clamp flag against a fixed-point predictor. Each
// result is checked in order. Stimulus is directed corners followed by unit
// quaternions, near gimbal lock cases and raw bit patterns. Both sides idle.
// ----------------------------------------------------------------------------
class euler_scoreboard;
	qte_pkg::qte_result_t pending_angles[$];
	int errors = 0;

	static function longint asr(longint v, int n);
		return v >>> n;
	endfunction

	static function longint q30_mul(longint a, longint b);
		return asr(a * b, 30);
	endfunction

	static function longint root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	static function longint arc_tan(int i);
		longint t[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return t[i];
	endfunction

	// Vectoring rotation; a vector in the left half plane is turned by pi first.
	static function longint vector_angle(longint y, longint x);
		longint acc;
		longint dx;
		longint dy;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			acc = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < qte_pkg::ITER; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				acc = acc + arc_tan(i);
			end else begin
				x = x - dx;
				y = y + dy;
				acc = acc - arc_tan(i);
			end
		end
		return acc;
	endfunction

	static function longint scale_angle(longint acc, longint lim);
		longint v;
		v = asr(acc * 5730 + (64'sd1 << 29), 30);
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v;
	endfunction

	function void note_quat(logic signed [31:0] qw, logic signed [31:0] qx,
			logic signed [31:0] qy, logic signed [31:0] qz);
		longint w, x, y, z, s, c, ry, rx, yy, yx;
		qte_pkg::qte_result_t r;
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		r.clamped = 1'b0;
		s = 2 * (q30_mul(w, y) - q30_mul(x, z));
		if (s > 64'sd1073741824) begin
			s = 64'sd1073741824;
			r.clamped = 1'b1;
		end else if (s < -64'sd1073741824) begin
			s = -64'sd1073741824;
			r.clamped = 1'b1;
		end
		c = root_floor(longint'(64'd1 << 60) - s * s);
		ry = 2 * (q30_mul(y, z) + q30_mul(w, x));
		rx = 64'sd1073741824 - 2 * q30_mul(x, x) - 2 * q30_mul(y, y);
		yy = 2 * (q30_mul(x, y) + q30_mul(w, z));
		yx = q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y) - q30_mul(z, z);
		r.roll = 16'(scale_angle(vector_angle(ry, rx), 18001));
		r.pitch = 15'(scale_angle(vector_angle(s, c), 9001));
		r.yaw = 16'(scale_angle(vector_angle(yy, yx), 18001));
		pending_angles.push_back(r);
	endfunction

	function void check_angles(qte_pkg::qte_result_t got);
		qte_pkg::qte_result_t exp_r;
		if (pending_angles.size() == 0) begin
			$error("result with no quaternion outstanding");
			errors++;
			return;
		end
		exp_r = pending_angles.pop_front();
		if (got.roll !== exp_r.roll) begin
			$error("roll_angle expected %0d actual %0d", exp_r.roll, got.roll);
			errors++;
		end
		if (got.pitch !== exp_r.pitch) begin
			$error("pitch_angle expected %0d actual %0d", exp_r.pitch, got.pitch);
			errors++;
		end
		if (got.yaw !== exp_r.yaw) begin
			$error("yaw_angle expected %0d actual %0d", exp_r.yaw, got.yaw);
			errors++;
		end
		if (got.clamped !== exp_r.clamped) begin
			$error("pitch_clamped expected %0b actual %0b", exp_r.clamped, got.clamped);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import qte_pkg::*;

	localparam int ONE = 1073741824;
	localparam int IDLE_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic signed [31:0] quat_w = '0;
	logic signed [31:0] quat_x = '0;
	logic signed [31:0] quat_y = '0;
	logic signed [31:0] quat_z = '0;
	logic full;
	logic empty;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic pitch_clamped;

	euler_scoreboard angle_board = new();
	int hold_off = 0;
	int idle_cycles = 0;

	quaternion_to_euler_angles_top dut (
		.clk, .arst_n, .push, .full, .quat_w, .quat_x, .quat_y, .quat_z,
		.empty, .pop, .roll_angle, .pitch_angle, .yaw_angle, .pitch_clamped
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Holds the item on the ports until a transfer takes place.
	task automatic send_quat(logic signed [31:0] w, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		push <= 1'b1;
		quat_w <= w;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		@(posedge clk);
		while (full)
			@(posedge clk);
		angle_board.note_quat(w, x, y, z);
	endtask

	function automatic real unit_rand();
		return ($urandom / 4294967295.0) * 2.0 - 1.0;
	endfunction

	task automatic send_random();
		real a[4];
		real n;
		int kind;
		logic signed [31:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			n = 0.0;
			foreach (a[i]) begin
				a[i] = unit_rand();
				n = n + a[i] * a[i];
			end
			n = $sqrt(n);
			if (n < 1.0e-3)
				n = 1.0;
			send_quat($rtoi(a[0] / n * ONE), $rtoi(a[1] / n * ONE),
				$rtoi(a[2] / n * ONE), $rtoi(a[3] / n * ONE));
		end else if (kind < 75) begin
			// Close to gimbal lock, where the sine may round past one.
			c = 759250125 + $signed($urandom_range(0, 200)) - 100;
			send_quat($urandom_range(0, 1) ? c : -c,
				$signed($urandom_range(0, 4000)) - 2000,
				$urandom_range(0, 1) ? c : -c,
				$signed($urandom_range(0, 4000)) - 2000);
		end else if (kind < 90) begin
			send_quat($urandom, $urandom, $urandom, $urandom);
		end else begin
			send_quat($signed($urandom_range(0, 64)) - 32, $signed($urandom_range(0, 64)) - 32,
				$urandom_range(0, 1) ? ONE : -ONE, $signed($urandom_range(0, 2)) - 1);
		end
	endtask

	initial begin
		int gap;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_quat(0, 0, 0, 0);
		send_quat(ONE, 0, 0, 0);
		send_quat(-ONE, 0, 0, 0);
		send_quat(0, ONE, 0, 0);
		send_quat(0, 0, ONE, 0);
		send_quat(0, 0, 0, ONE);
		send_quat(0, 0, 0, -ONE);
		send_quat(759250125, 0, 759250125, 0);
		send_quat(759250125, 0, -759250125, 0);
		send_quat(ONE, ONE, ONE, ONE);
		send_quat(ONE, -ONE, ONE, -ONE);
		send_quat(-ONE, -ONE, -ONE, -ONE);
		send_quat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_quat(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_quat(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_quat(0, 0, 0, 32'sh80000000);
		send_quat(1, -1, 1, -1);
		send_quat(-1, -1, -1, -1);
		send_quat(0, ONE, ONE, 0);
		send_quat(0, 0, ONE, -ONE);
		for (int n = 0; n < 1650; n++) begin
			if (n == 400)
				hold_off = 400;
			if (n == 1000) begin
				push <= 1'b0;
				while (angle_board.pending_angles.size() != 0)
					@(posedge clk);
			end
			send_random();
			if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 12);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;
		while (angle_board.pending_angles.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (angle_board.errors == 0 && angle_board.pending_angles.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: checks each transfer, then picks its pop pattern.
	initial begin
		int mode;
		int mode_left;
		qte_result_t got;
		mode = 0;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.roll = roll_angle;
				got.pitch = pitch_angle;
				got.yaw = yaw_angle;
				got.clamped = pitch_clamped;
				angle_board.check_angles(got);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_off > 0) begin
				hold_off--;
				pop <= 1'b0;
			end else if (mode == 0)
				pop <= 1'b1;
			else if (mode == 1)
				pop <= $urandom_range(0, 1);
			else
				pop <= ($urandom_range(0, 7) == 0);
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end
endmodule
